// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while reset is high.
`define WPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpp assertion failed");

// Implication checked in the following cycle, masked while reset is high.
`define WPP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpp assertion failed");

// Implication checked in the following cycle, also during reset.
`define WPP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("wpp assertion failed");

`endif

// ===== rtl/wpp_pkg.sv =====
// ----------------------------------------------------------------------------
// wpp_pkg
// Types and constants of the WAV PCM stream parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

   localparam int SMP_BYTES   = 4;   // stored sample bytes: two per channel, two channels
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;
   localparam logic [5:0]  MIN_FILE = 6'd44;
   localparam logic [31:0] MIN_FMT  = 32'd16;
   localparam logic [15:0] FMT_PCM  = 16'd1;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_OK    = 2'd1;
   localparam logic [1:0] KIND_ERR   = 2'd2;

   // One queue entry: what one input word produced
   typedef struct packed {
      logic        has_frame;
      logic        has_end;
      logic        end_ok;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic [31:0] rate_hz;
      logic [15:0] channel_count;
      logic [15:0] sample_bits;
   } entry_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/wpp_ifs.sv =====
// ----------------------------------------------------------------------------
// wpp_req_if / wpp_rsp_if
// Valid/ready channels carrying input words and result items.
// ----------------------------------------------------------------------------
interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface wpp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;
   logic [31:0]        rate_hz;
   logic [15:0]        channel_count;
   logic [15:0]        sample_bits;
   logic               last_item;

   modport source (output valid, output kind, output left_sample, output right_sample,
                   output rate_hz, output channel_count, output sample_bits,
                   output last_item, input ready);
   modport sink   (input valid, input kind, input left_sample, input right_sample,
                   input rate_hz, input channel_count, input sample_bits,
                   input last_item, output ready);
endinterface

// ===== rtl/wpp_front.sv =====
// ----------------------------------------------------------------------------
// wpp_front
// Byte parser: walks RIFF/WAVE chunks, captures fmt fields, assembles frames
// and pushes one queue entry for every word that yields a result.
// ----------------------------------------------------------------------------
module wpp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_final,
   input  wpp_pkg::qstat_type qstat,
   output logic               push,
   output wpp_pkg::entry_type push_entry
);

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RSIZE = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_CHDR  = 4'd3;
   localparam logic [3:0] PH_SKIP  = 4'd4;
   localparam logic [3:0] PH_FMT   = 4'd5;
   localparam logic [3:0] PH_DATA  = 4'd6;
   localparam logic [3:0] PH_PAD   = 4'd7;
   localparam logic [3:0] PH_DEAD  = 4'd8;

   logic [3:0]  phase_ff,    phase_in;
   logic [5:0]  fbc_ff,      fbc_in;
   logic [31:0] tag_ff,      tag_in;
   logic [31:0] rem_ff,      rem_in;
   logic        pad_ff,      pad_in;
   logic [15:0] ftag_ff,     ftag_in;
   logic [15:0] chan_ff,     chan_in;
   logic [31:0] rate_ff,     rate_in;
   logic [15:0] bits_ff,     bits_in;
   logic        found_ff,    found_in;
   logic        ddone_ff,    ddone_in;
   logic [4:0]  idx_ff,      idx_in;
   logic [12:0] bk_ff,       bk_in;
   logic [15:0] bc_ff,       bc_in;
   logic [7:0]  smp_ff [wpp_pkg::SMP_BYTES];
   logic [7:0]  smp_in [wpp_pkg::SMP_BYTES];

   logic        accept;
   logic [15:0] chans_eff, bits_eff, chans_in_eff, bits_in_eff;
   logic [12:0] bps;
   logic        pcm_ok, ok_end;
   logic [31:0] rem_dec, csize;
   logic        frame_end;
   logic [15:0] left_w, right_w;

   assign accept    = in_valid && !qstat.full;
   assign chans_eff = (chan_ff == 16'd0) ? 16'd1 : chan_ff;
   assign bits_eff  = (bits_ff == 16'd0) ? 16'd16 : bits_ff;
   assign bps       = bits_eff[15:3];
   assign pcm_ok    = found_ff && (ftag_ff == wpp_pkg::FMT_PCM) && (bps != 13'd0);
   assign rem_dec   = rem_ff - 32'd1;
   assign csize     = {in_byte, rem_ff[23:0]};

   always_comb begin
      phase_in  = phase_ff;
      fbc_in    = (fbc_ff < wpp_pkg::MIN_FILE) ? fbc_ff + 6'd1 : fbc_ff;
      tag_in    = tag_ff;
      rem_in    = rem_ff;
      pad_in    = pad_ff;
      ftag_in   = ftag_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      found_in  = found_ff;
      ddone_in  = ddone_ff;
      idx_in    = idx_ff;
      bk_in     = bk_ff;
      bc_in     = bc_ff;
      smp_in    = smp_ff;
      frame_end = 1'b0;
      left_w    = 16'd0;
      right_w   = 16'd0;

      case (phase_ff)
         PH_RIFF, PH_WAVE: begin
            tag_in = {tag_ff[23:0], in_byte};
            idx_in = idx_ff + 5'd1;
            if (idx_ff == 5'd3) begin
               if (phase_ff == PH_RIFF)
                  phase_in = (tag_in == wpp_pkg::TAG_RIFF) ? PH_RSIZE : PH_DEAD;
               else
                  phase_in = (tag_in == wpp_pkg::TAG_WAVE) ? PH_CHDR : PH_DEAD;
               idx_in = 5'd0;
               rem_in = 32'd0;
               pad_in = 1'b0;
            end
         end
         PH_RSIZE: begin
            if (idx_ff == 5'd3) begin
               idx_in   = 5'd0;
               phase_in = PH_WAVE;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         PH_CHDR: begin
            idx_in = idx_ff + 5'd1;
            if (idx_ff < 5'd4)
               tag_in = {tag_ff[23:0], in_byte};
            else
               rem_in[8*idx_ff[1:0] +: 8] = in_byte;
            if (idx_ff == 5'd7) begin
               // chunk header complete: open the body
               rem_in = csize;
               pad_in = csize[0];
               idx_in = 5'd0;
               if (tag_ff == wpp_pkg::TAG_FMT && csize >= wpp_pkg::MIN_FMT) begin
                  if (ddone_ff) begin
                     phase_in = PH_DEAD;
                  end else begin
                     found_in = 1'b1;
                     ftag_in  = 16'd0;
                     chan_in  = 16'd0;
                     rate_in  = 32'd0;
                     bits_in  = 16'd0;
                     phase_in = PH_FMT;
                  end
               end else if (tag_ff == wpp_pkg::TAG_DATA && !ddone_ff) begin
                  ddone_in = 1'b1;
                  for (int i = 0; i < wpp_pkg::SMP_BYTES; i++) smp_in[i] = 8'd0;
                  bk_in    = 13'd0;
                  bc_in    = 16'd0;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_SKIP;
               end
               if (csize == 32'd0 && phase_in != PH_DEAD) begin
                  phase_in = PH_CHDR;
                  rem_in   = 32'd0;
                  pad_in   = 1'b0;
               end
            end
         end
         PH_FMT, PH_DATA, PH_SKIP: begin
            if (phase_ff == PH_FMT) begin
               case (idx_ff)
                  5'd0:  ftag_in[7:0]   = in_byte;
                  5'd1:  ftag_in[15:8]  = in_byte;
                  5'd2:  chan_in[7:0]   = in_byte;
                  5'd3:  chan_in[15:8]  = in_byte;
                  5'd4:  rate_in[7:0]   = in_byte;
                  5'd5:  rate_in[15:8]  = in_byte;
                  5'd6:  rate_in[23:16] = in_byte;
                  5'd7:  rate_in[31:24] = in_byte;
                  5'd14: bits_in[7:0]   = in_byte;
                  5'd15: bits_in[15:8]  = in_byte;
                  default: ;
               endcase
               // offsets past the fields only need to stay past them
               idx_in = (idx_ff == 5'd31) ? idx_ff : idx_ff + 5'd1;
            end
            if (phase_ff == PH_DATA && pcm_ok) begin
               if (bc_ff < 16'd2 && bk_ff < 13'd2)
                  smp_in[{bc_ff[0], bk_ff[0]}] = in_byte;
               left_w  = {smp_in[1], smp_in[0]};
               right_w = (chans_eff == 16'd2) ? {smp_in[3], smp_in[2]} : left_w;
               if (bk_ff == bps - 13'd1) begin
                  bk_in = 13'd0;
                  if (bc_ff == chans_eff - 16'd1) begin
                     frame_end = 1'b1;
                     bc_in     = 16'd0;
                     for (int i = 0; i < wpp_pkg::SMP_BYTES; i++) smp_in[i] = 8'd0;
                  end else begin
                     bc_in = bc_ff + 16'd1;
                  end
               end else begin
                  bk_in = bk_ff + 13'd1;
               end
            end
            rem_in = rem_dec;
            if (rem_dec == 32'd0) begin
               phase_in = pad_ff ? PH_PAD : PH_CHDR;
               pad_in   = 1'b0;
               idx_in   = 5'd0;
               bk_in    = 13'd0;
               bc_in    = 16'd0;
            end
         end
         PH_PAD: begin
            phase_in = PH_CHDR;
            idx_in   = 5'd0;
         end
         default: phase_in = PH_DEAD;
      endcase
   end

   assign chans_in_eff = (chan_in == 16'd0) ? 16'd1 : chan_in;
   assign bits_in_eff  = (bits_in == 16'd0) ? 16'd16 : bits_in;
   assign ok_end = (fbc_in >= wpp_pkg::MIN_FILE) && (phase_in != PH_DEAD) && found_in &&
                   (ftag_in == wpp_pkg::FMT_PCM) && (bits_in_eff[15:3] != 13'd0);

   assign push = accept && (frame_end || in_final);

   always_comb begin
      push_entry               = '0;
      push_entry.has_frame     = frame_end;
      push_entry.has_end       = in_final;
      push_entry.end_ok        = ok_end;
      push_entry.left_sample   = left_w;
      push_entry.right_sample  = right_w;
      push_entry.rate_hz       = rate_in;
      push_entry.channel_count = chans_in_eff;
      push_entry.sample_bits   = bits_in_eff;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_final)) begin
         // the last word of a file returns the parser to its reset state
         phase_ff <= PH_RIFF;
         fbc_ff   <= 6'd0;
         tag_ff   <= 32'd0;
         rem_ff   <= 32'd0;
         pad_ff   <= 1'b0;
         ftag_ff  <= 16'd0;
         chan_ff  <= 16'd0;
         rate_ff  <= 32'd0;
         bits_ff  <= 16'd0;
         found_ff <= 1'b0;
         ddone_ff <= 1'b0;
         idx_ff   <= 5'd0;
         bk_ff    <= 13'd0;
         bc_ff    <= 16'd0;
         for (int i = 0; i < wpp_pkg::SMP_BYTES; i++) smp_ff[i] <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         tag_ff   <= tag_in;
         rem_ff   <= rem_in;
         pad_ff   <= pad_in;
         ftag_ff  <= ftag_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         found_ff <= found_in;
         ddone_ff <= ddone_in;
         idx_ff   <= idx_in;
         bk_ff    <= bk_in;
         bc_ff    <= bc_in;
         smp_ff   <= smp_in;
      end
   end

endmodule

// ===== rtl/wpp_queue.sv =====
// ----------------------------------------------------------------------------
// wpp_queue
// Short FIFO of parsed entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module wpp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wpp_pkg::entry_type push_entry,
   input  logic               pop,
   output wpp_pkg::entry_type head,
   output wpp_pkg::qstat_type qstat
);

   wpp_pkg::entry_type             slot_ff [wpp_pkg::QUEUE_DEPTH];
   logic [wpp_pkg::QPTR_W-1:0]     wr_ff, wr_in;
   logic [wpp_pkg::QPTR_W-1:0]     rd_ff, rd_in;
   logic [wpp_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign qstat.full  = (cnt_ff == wpp_pkg::QCNT_W'(wpp_pkg::QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// ===== rtl/wpp_back.sv =====
// ----------------------------------------------------------------------------
// wpp_back
// Output stage: splits a queue entry into a frame word and an end word and
// holds each in the output register until taken.
// ----------------------------------------------------------------------------
module wpp_back (
   input  logic               clock,
   input  logic               reset,
   input  wpp_pkg::entry_type head,
   input  wpp_pkg::qstat_type qstat,
   output logic               pop,
   wpp_rsp_if.source          rsp
);

   logic               val_ff,   val_in;
   logic               split_ff, split_in;
   logic [1:0]         kind_ff,  kind_in;
   logic signed [15:0] left_ff,  left_in;
   logic signed [15:0] right_ff, right_in;
   logic [31:0]        rate_ff,  rate_in;
   logic [15:0]        chan_ff,  chan_in;
   logic [15:0]        bits_ff,  bits_in;
   logic               last_ff,  last_in;
   logic               load;

   assign load = !val_ff || rsp.ready;

   always_comb begin
      val_in   = val_ff;
      split_in = split_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      right_in = right_ff;
      rate_in  = rate_ff;
      chan_in  = chan_ff;
      bits_in  = bits_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         val_in = !qstat.empty;
         if (!qstat.empty) begin
            rate_in = head.rate_hz;
            chan_in = head.channel_count;
            bits_in = head.sample_bits;
            if (head.has_frame && !split_ff) begin
               kind_in  = wpp_pkg::KIND_FRAME;
               left_in  = head.left_sample;
               right_in = head.right_sample;
               last_in  = 1'b0;
               // keep the entry when its end word is still due
               split_in = head.has_end;
               pop      = !head.has_end;
            end else begin
               kind_in  = head.end_ok ? wpp_pkg::KIND_OK : wpp_pkg::KIND_ERR;
               left_in  = 16'sd0;
               right_in = 16'sd0;
               last_in  = 1'b1;
               split_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff   <= 1'b0;
         split_ff <= 1'b0;
      end else begin
         val_ff   <= val_in;
         split_ff <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      rate_ff  <= rate_in;
      chan_ff  <= chan_in;
      bits_ff  <= bits_in;
      last_ff  <= last_in;
   end

   assign rsp.valid         = val_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.left_sample   = left_ff;
   assign rsp.right_sample  = right_ff;
   assign rsp.rate_hz       = rate_ff;
   assign rsp.channel_count = chan_ff;
   assign rsp.sample_bits   = bits_ff;
   assign rsp.last_item     = last_ff;

endmodule

// ===== rtl/wav_pcm_stream_parser.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// Parses a RIFF/WAVE PCM file given one byte per word into stereo frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one byte of the file per word; final_byte marks the last.
//   rsp_ch returns stereo frames (kind 0) and one end word per file (kind 1
//   success, kind 2 error, last_item set). The fmt fields ride on every word.
// Throughput: one byte per cycle while the queue is not full. A byte that
//   completes a frame and also ends the file yields two result words, the
//   frame word first and then the end word. A byte's entry is written into
//   the queue at the edge that accepts the byte and moves into the output
//   register once that register is empty or being taken by rsp_ch.
// The parser sits in front of a 4-entry queue; req_ch.ready falls only while
//   that queue is full, so a stalled receiver backs up into the sender after
//   the queue and the output register have filled.
// Reset clears the parser, the queue and the output valid; no clearing pass
//   is needed. The parser also returns to its reset state after every
//   final byte, so the next byte starts a new file.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser (
   input  logic      clock,
   input  logic      reset,
   wpp_req_if.sink   req_ch,
   wpp_rsp_if.source rsp_ch
);

   wpp_pkg::entry_type push_entry;
   wpp_pkg::entry_type head;
   wpp_pkg::qstat_type qstat;
   logic               push;
   logic               pop;

   assign req_ch.ready = !qstat.full;

   wpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_byte    (req_ch.data_byte),
      .in_final   (req_ch.final_byte),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   wpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   wpp_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

// ===== rtl/wpp_checker.sv =====
// ----------------------------------------------------------------------------
// wpp_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_left,
   input logic [15:0] rsp_channels,
   input logic [15:0] rsp_bits,
   input logic        rsp_last
);

   // a stalled word holds
   `WPP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_kind) && $stable(rsp_left))

   // only end words close a file, and every end word does
   `WPP_ASSERT_IMP(a_last_kind, clock, reset, rsp_valid,
                   rsp_last == (rsp_kind != wpp_pkg::KIND_FRAME))

   // zero fmt fields are replaced before they leave
   `WPP_ASSERT_IMP(a_fmt_nonzero, clock, reset, rsp_valid,
                   rsp_channels != 16'd0 && rsp_bits != 16'd0)

   `WPP_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind wav_pcm_stream_parser wpp_checker u_wpp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_left     (rsp_ch.left_sample),
   .rsp_channels (rsp_ch.channel_count),
   .rsp_bits     (rsp_ch.sample_bits),
   .rsp_last     (rsp_ch.last_item)
);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for wav_pcm_stream_parser. A short table of hand-made
// broken files comes first, then randomly built WAV files: mostly well-formed,
// with odd chunks, overridden or late fmt chunks, truncation and plain noise.
// Every accepted byte runs through a local parser model, and each result word
// is compared field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_BYTES = 950;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 16;
   localparam int MAX_PRINTS   = 50;

   localparam logic [3:0] PH_RIFF_TAG  = 4'd0;
   localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
   localparam logic [3:0] PH_WAVE_TAG  = 4'd2;
   localparam logic [3:0] PH_CHUNK_HDR = 4'd3;
   localparam logic [3:0] PH_SKIP_BODY = 4'd4;
   localparam logic [3:0] PH_FMT_BODY  = 4'd5;
   localparam logic [3:0] PH_DATA_BODY = 4'd6;
   localparam logic [3:0] PH_PAD_BYTE  = 4'd7;
   localparam logic [3:0] PH_STOPPED   = 4'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] left_smp;
      logic [15:0] right_smp;
      logic [31:0] rate;
      logic [15:0] chans;
      logic [15:0] depth;
      logic        last;
   } wav_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       typed;
   } stim_row_type;

   // end word of a file that failed before any fmt chunk
   localparam wav_item_type EARLY_ERROR_END = '{kind: wpp_pkg::KIND_ERR, left_smp: 16'd0,
      right_smp: 16'd0, rate: 32'd0, chans: 16'd1, depth: 16'd16, last: 1'b1};

   // short and bad-tag files; the end word of each is known from reset values
   stim_row_type directed_rows [23] = '{
      '{8'h00, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b1},
      '{8'h52, 1'b0, 1'b0}, '{8'h49, 1'b0, 1'b0}, '{8'h46, 1'b0, 1'b0},
      '{8'h46, 1'b1, 1'b1},
      '{8'h52, 1'b0, 1'b0}, '{8'h49, 1'b0, 1'b0}, '{8'h46, 1'b0, 1'b0},
      '{8'h58, 1'b0, 1'b0}, '{8'hAA, 1'b1, 1'b1},
      '{8'h52, 1'b0, 1'b0}, '{8'h49, 1'b0, 1'b0}, '{8'h46, 1'b0, 1'b0},
      '{8'h46, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0},
      '{8'h57, 1'b0, 1'b0}, '{8'h41, 1'b0, 1'b0}, '{8'h56, 1'b0, 1'b0},
      '{8'h46, 1'b1, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   wpp_req_if req_ch ();
   wpp_rsp_if rsp_ch ();

   wav_pcm_stream_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // parser model state
   logic [3:0]   ph;
   logic [5:0]   seen_bytes;
   logic [31:0]  hdr_tag;
   logic [31:0]  body_left;
   logic         pad_due;
   logic [15:0]  fmt_code;
   logic [15:0]  fmt_chans;
   logic [31:0]  fmt_rate;
   logic [15:0]  fmt_bits;
   logic         fmt_valid;
   logic         data_started;
   logic [31:0]  byte_pos;
   logic [7:0]   held [wpp_pkg::SMP_BYTES];

   wav_item_type wav_items_due [$];
   wav_item_type step_items [$];
   logic [7:0] wav_bytes [$];

   bit idle_on = 1'b1;
   int unsigned stall_requests = 0;
   int unsigned stalls_done = 0;
   int unsigned bytes_sent = 0;
   int unsigned files_built = 0;
   int unsigned frames_seen = 0;
   int unsigned ok_ends = 0;
   int unsigned err_ends = 0;
   int unsigned words_seen = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   function automatic logic [31:0] chan_total();
      return (fmt_chans == 16'd0) ? 32'd1 : {16'd0, fmt_chans};
   endfunction

   function automatic logic [31:0] bit_depth();
      return (fmt_bits == 16'd0) ? 32'd16 : {16'd0, fmt_bits};
   endfunction

   function automatic logic [31:0] frame_len();
      return (bit_depth() / 32'd8) * chan_total();
   endfunction

   function automatic wav_item_type make_item(logic [1:0] k, logic [15:0] l, logic [15:0] r,
                                              logic last);
      wav_item_type it;
      logic [31:0] c;
      logic [31:0] d;
      c = chan_total();
      d = bit_depth();
      it.kind = k;
      it.left_smp = l;
      it.right_smp = r;
      it.rate = fmt_rate;
      it.chans = c[15:0];
      it.depth = d[15:0];
      it.last = last;
      return it;
   endfunction

   task automatic clear_held();
      foreach (held[i]) held[i] = 8'd0;
   endtask

   task automatic clear_parser();
      ph = PH_RIFF_TAG;
      seen_bytes = '0;
      hdr_tag = '0;
      body_left = '0;
      pad_due = 1'b0;
      fmt_code = '0;
      fmt_chans = '0;
      fmt_rate = '0;
      fmt_bits = '0;
      fmt_valid = 1'b0;
      data_started = 1'b0;
      byte_pos = '0;
      clear_held();
   endtask

   task automatic close_body();
      ph = pad_due ? PH_PAD_BYTE : PH_CHUNK_HDR;
      body_left = '0;
      pad_due = 1'b0;
      byte_pos = '0;
   endtask

   task automatic consume_body();
      body_left = body_left - 32'd1;
      if (body_left == 32'd0) close_body();
   endtask

   task automatic open_body();
      logic [31:0] csize;
      csize = body_left;
      pad_due = csize[0];
      byte_pos = '0;
      if (hdr_tag == wpp_pkg::TAG_FMT && csize >= wpp_pkg::MIN_FMT) begin
         // a full fmt chunk once data has begun kills the file
         if (data_started) begin
            ph = PH_STOPPED;
         end else begin
            fmt_valid = 1'b1;
            fmt_code = '0;
            fmt_chans = '0;
            fmt_rate = '0;
            fmt_bits = '0;
            ph = PH_FMT_BODY;
         end
      end else if (hdr_tag == wpp_pkg::TAG_DATA && !data_started) begin
         data_started = 1'b1;
         clear_held();
         ph = PH_DATA_BODY;
      end else begin
         ph = PH_SKIP_BODY;
      end
      if (csize == 32'd0) close_body();
   endtask

   // advance the model by one byte; results land in step_items
   task automatic parse_wav_byte(input logic [7:0] b, input logic fin);
      logic [31:0] want;
      logic [31:0] bpf;
      logic [31:0] bps;
      logic [31:0] ch;
      logic [31:0] k;
      logic [15:0] smp_l;
      logic [15:0] smp_r;
      logic ok;
      step_items.delete();
      if (seen_bytes < wpp_pkg::MIN_FILE) seen_bytes++;
      case (ph)
         PH_RIFF_TAG, PH_WAVE_TAG: begin
            hdr_tag = {hdr_tag[23:0], b};
            byte_pos++;
            if (byte_pos == 32'd4) begin
               want = (ph == PH_RIFF_TAG) ? wpp_pkg::TAG_RIFF : wpp_pkg::TAG_WAVE;
               if (hdr_tag != want) ph = PH_STOPPED;
               else ph = (ph == PH_RIFF_TAG) ? PH_RIFF_SIZE : PH_CHUNK_HDR;
               byte_pos = '0;
               body_left = '0;
               pad_due = 1'b0;
            end
         end
         PH_RIFF_SIZE: begin
            byte_pos++;
            if (byte_pos == 32'd4) begin
               byte_pos = '0;
               ph = PH_WAVE_TAG;
            end
         end
         PH_CHUNK_HDR: begin
            if (byte_pos < 32'd4) hdr_tag = {hdr_tag[23:0], b};
            else body_left = body_left | ({24'd0, b} << (8 * (byte_pos - 32'd4)));
            byte_pos++;
            if (byte_pos == 32'd8) open_body();
         end
         PH_FMT_BODY: begin
            case (byte_pos)
               0: fmt_code[7:0] = b;
               1: fmt_code[15:8] = b;
               2: fmt_chans[7:0] = b;
               3: fmt_chans[15:8] = b;
               4, 5, 6, 7: fmt_rate[8 * (byte_pos - 4) +: 8] = b;
               14: fmt_bits[7:0] = b;
               15: fmt_bits[15:8] = b;
               default: ;
            endcase
            byte_pos++;
            consume_body();
         end
         PH_DATA_BODY: begin
            bpf = frame_len();
            if (fmt_valid && fmt_code == wpp_pkg::FMT_PCM && bpf >= 32'd1) begin
               bps = bit_depth() / 32'd8;
               ch = byte_pos / bps;
               k = byte_pos % bps;
               // keep only the low two bytes of the first two channels
               if (ch < 32'd2 && k < 32'd2) held[{ch[0], k[0]}] = b;
               byte_pos++;
               if (byte_pos >= bpf) begin
                  smp_l = {held[1], held[0]};
                  smp_r = (chan_total() == 32'd2) ? {held[3], held[2]} : smp_l;
                  step_items.push_back(make_item(wpp_pkg::KIND_FRAME, smp_l, smp_r, 1'b0));
                  byte_pos = '0;
                  clear_held();
               end
            end
            consume_body();
         end
         PH_SKIP_BODY: consume_body();
         PH_PAD_BYTE: begin
            ph = PH_CHUNK_HDR;
            byte_pos = '0;
         end
         default: ph = PH_STOPPED;
      endcase
      if (fin) begin
         ok = seen_bytes >= wpp_pkg::MIN_FILE && ph != PH_STOPPED && fmt_valid &&
              fmt_code == wpp_pkg::FMT_PCM && frame_len() >= 32'd1;
         step_items.push_back(make_item(ok ? wpp_pkg::KIND_OK : wpp_pkg::KIND_ERR,
                                        16'd0, 16'd0, 1'b1));
         clear_parser();
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed);
      while (idle_on && $urandom_range(99) < 38) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.final_byte <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      parse_wav_byte(b, fin);
      if (typed) wav_items_due.push_back(EARLY_ERROR_END);
      else foreach (step_items[i]) wav_items_due.push_back(step_items[i]);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_tag(input logic [31:0] t);
      wav_bytes.push_back(t[31:24]);
      wav_bytes.push_back(t[23:16]);
      wav_bytes.push_back(t[15:8]);
      wav_bytes.push_back(t[7:0]);
   endtask

   task automatic put_le32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8 * i +: 8]);
   endtask

   task automatic put_random(input int n);
      for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
   endtask

   task automatic put_junk_chunk();
      int len;
      len = $urandom_range(0, 7);
      put_tag($urandom);
      put_le32(len);
      put_random(len + (len % 2));
   endtask

   task automatic put_fmt(input logic [15:0] code, input logic [15:0] chans,
                          input logic [15:0] depth);
      logic [127:0] img;
      int len;
      int r;
      r = $urandom_range(99);
      len = (r < 70) ? 16 : (r < 85) ? 18 : (r < 94) ? $urandom_range(17, 26)
                                                      : $urandom_range(0, 15);
      img = {depth, 16'($urandom), 32'($urandom), 32'($urandom), chans, code};
      put_tag(wpp_pkg::TAG_FMT);
      put_le32(len);
      for (int i = 0; i < len; i++) begin
         if (i < 16) wav_bytes.push_back(img[8 * i +: 8]);
         else wav_bytes.push_back(8'($urandom));
      end
      if (len % 2 == 1) put_random(1);
   endtask

   function automatic logic [15:0] pick_chans();
      int r;
      r = $urandom_range(99);
      if (r < 35) return 16'd1;
      if (r < 75) return 16'd2;
      if (r < 83) return 16'd0;
      if (r < 93) return 16'($urandom_range(3, 6));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_depth();
      int r;
      r = $urandom_range(99);
      if (r < 25) return 16'd8;
      if (r < 60) return 16'd16;
      if (r < 72) return 16'd24;
      if (r < 80) return 16'd32;
      if (r < 86) return 16'd0;
      if (r < 92) return 16'($urandom_range(1, 7));
      return 16'($urandom);
   endfunction

   // fill wav_bytes with one file: mostly well-formed, sometimes broken or noise
   task automatic build_wav_file();
      int style;
      int r;
      int nfmt;
      int eff_c;
      int eff_b;
      int bpf;
      int data_len;
      int declared;
      bit cut_short;
      logic [15:0] code;
      logic [15:0] chans;
      logic [15:0] depth;
      wav_bytes.delete();
      style = $urandom_range(99);
      cut_short = 1'b0;
      chans = 16'd1;
      depth = 16'd16;
      if (style < 10) begin
         put_random($urandom_range(1, 50));
      end else begin
         put_tag((style < 14) ? wpp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31))
                              : wpp_pkg::TAG_RIFF);
         put_le32($urandom);
         put_tag((style >= 14 && style < 18)
                 ? wpp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(31)) : wpp_pkg::TAG_WAVE);
         if ($urandom_range(99) < 25) put_junk_chunk();
         r = $urandom_range(99);
         nfmt = (r < 5) ? 0 : (r < 11) ? 2 : 1;
         for (int i = 0; i < nfmt; i++) begin
            code = ($urandom_range(99) < 88) ? wpp_pkg::FMT_PCM : 16'($urandom);
            chans = pick_chans();
            depth = pick_depth();
            put_fmt(code, chans, depth);
         end
         if ($urandom_range(99) < 90) begin
            eff_c = (chans == 16'd0) ? 1 : int'(chans);
            eff_b = (depth == 16'd0) ? 16 : int'(depth);
            bpf = (eff_b / 8) * eff_c;
            if (bpf >= 1 && bpf <= 16) begin
               data_len = $urandom_range(0, 8) * bpf;
               if ($urandom_range(99) < 25) data_len += $urandom_range(bpf - 1);
            end else begin
               data_len = $urandom_range(0, 24);
            end
            // a declared size past the end of the file cuts the data short
            cut_short = ($urandom_range(99) < 12);
            declared = cut_short ? data_len + $urandom_range(1, 300) : data_len;
            put_tag(wpp_pkg::TAG_DATA);
            put_le32(declared);
            put_random(data_len);
            if (!cut_short) begin
               if (data_len % 2 == 1) put_random(1);
               r = $urandom_range(99);
               if (r < 10) begin
                  put_tag(wpp_pkg::TAG_DATA);
                  put_le32(4);
                  put_random(4);
               end else if (r < 20) begin
                  put_fmt(wpp_pkg::FMT_PCM, pick_chans(), pick_depth());
               end else if (r < 32) begin
                  put_junk_chunk();
               end
            end
         end
         if ($urandom_range(99) < 7 && wav_bytes.size() > 1) begin
            r = $urandom_range(1, wav_bytes.size() - 1);
            while (wav_bytes.size() > r) void'(wav_bytes.pop_back());
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'd0;
      req_ch.final_byte = 1'b0;
      clear_parser();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed);
      while (bytes_sent < RANDOM_BYTES + $size(directed_rows)) begin
         // a run of files with no gaps on either side
         idle_on = (files_built < 4 || files_built > 7);
         if (files_built == 2) stall_requests++;
         build_wav_file();
         foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == wav_bytes.size() - 1, 1'b0);
         files_built++;
      end
      req_ch.valid <= 1'b0;
      while (wav_items_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d bytes in %0d random files plus a table of broken headers",
               bytes_sent, files_built);
      $display("checked %0d words: %0d frames, %0d good ends, %0d error ends",
               words_seen, frames_seen, ok_ends, err_ends);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // result side: random gaps, plus one long hold-off to back up the input
   initial begin : rsp_drive
      int hold;
      forever begin
         if (stalls_done != stall_requests) begin
            stalls_done++;
            for (hold = 0; hold < HOLD_CYCLES; hold++) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 38);
            @(negedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTS) $display("mismatch at word %0d: %s", words_seen, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      wav_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (rsp_ch.kind == wpp_pkg::KIND_FRAME) frames_seen++;
         else if (rsp_ch.kind == wpp_pkg::KIND_OK) ok_ends++;
         else err_ends++;
         if (wav_items_due.size() == 0) begin
            report_mismatch($sformatf("word of kind %0d with nothing pending", rsp_ch.kind));
         end else begin
            want = wav_items_due.pop_front();
            check_field("kind", 32'(rsp_ch.kind), 32'(want.kind));
            check_field("left_sample", 32'($unsigned(rsp_ch.left_sample)),
                        32'(want.left_smp));
            check_field("right_sample", 32'($unsigned(rsp_ch.right_sample)),
                        32'(want.right_smp));
            check_field("rate_hz", rsp_ch.rate_hz, want.rate);
            check_field("channel_count", 32'(rsp_ch.channel_count), 32'(want.chans));
            check_field("sample_bits", 32'(rsp_ch.sample_bits), 32'(want.depth));
            check_field("last_item", 32'(rsp_ch.last_item), 32'(want.last));
         end
         words_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d words still pending", wav_items_due.size());
         $display("status: fail");
         $finish;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wpp_pkg.sv
rtl/wpp_ifs.sv
rtl/wpp_front.sv
rtl/wpp_queue.sv
rtl/wpp_back.sv
rtl/wav_pcm_stream_parser.sv
rtl/wpp_checker.sv
test/tb_top.sv
